>>> design/sib_pkg.sv
`timescale 1ns / 1ps
// Package for the snapshot interpolation buffer: request, response and ring
// entry types, sequencer states and ring index helpers. No dependencies.
package sib_pkg;

  localparam int RING_DEPTH = 16;
  localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int DIV_NUM_W  = 48;
  localparam int DIV_DEN_W  = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);
  localparam logic [31:0] AGE_MAX  = 32'd250;
  localparam logic [31:0] MS_PER_S = 32'd1000;
  localparam logic [30:0] MS_RECIP = 31'd1099511628;
  localparam logic [16:0] FRAC_ONE = 17'h10000;

  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [2:0] FLD_PX  = 3'd0;
  localparam logic [2:0] FLD_PY  = 3'd1;
  localparam logic [2:0] FLD_VX  = 3'd2;
  localparam logic [2:0] FLD_VY  = 3'd3;
  localparam logic [2:0] FLD_ROT = 3'd4;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic               kind;
    logic [31:0]        sample_time;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] rot_in;
    logic               want_pos;
    logic               want_vel;
  } in_req_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_rot;
  } out_rsp_t;

  typedef struct packed {
    logic [31:0]        stamp;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] rot;
  } snap_entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SRCH, S_CMP, S_TAIL, S_GETB, S_SQX, S_SQY, S_SQC, S_FRAC,
    S_FDIV, S_LMUL, S_LACC, S_EMUL, S_EDIVS, S_EDIV, S_EQHI, S_ELMUL,
    S_EACC, S_OUT
  } state_t;

  function automatic idx_t ring_next(idx_t i);
    return (i == idx_t'(RING_DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic idx_t ring_prev(idx_t i);
    return (i == '0) ? idx_t'(RING_DEPTH - 1) : idx_t'(i - 1'b1);
  endfunction

  function automatic logic signed [31:0] ent_field(snap_entry_t e, logic [2:0] k);
    logic signed [31:0] v;
    unique case (k)
      FLD_PX:  v = e.pos_x;
      FLD_PY:  v = e.pos_y;
      FLD_VX:  v = e.vel_x;
      FLD_VY:  v = e.vel_y;
      default: v = e.rot;
    endcase
    return v;
  endfunction

endpackage

>>> design/snapshot_interpolation_buffer.sv
`timescale 1ns / 1ps
// Snapshot interpolation buffer: ring of timestamped snapshots with query
// by interpolation, extrapolation or snap. A query searches the entries from
// newest to oldest, then snaps, extrapolates or interpolates (with a serial
// fraction divide) and loads the result register. One item at a time;
// input stalls until the result register is free. Synchronous active-low
// reset clears pointers and control.
module snapshot_interpolation_buffer
  import sib_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_rsp_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  state_t      state_r, state_nxt;
  idx_t        head_r, tail_r, cur_r, front_r, nb_r;
  in_req_t     req_r;
  logic [63:0] thr_r;
  snap_entry_t ent_a_r, ent_b_r, rd_data;
  idx_t        rd_addr;
  logic        wr_en;
  logic signed [31:0] res_r [5];
  logic        ok_r;
  logic [2:0]  k_r;
  logic [16:0] f_r;
  logic        neg_r;
  logic [41:0] mag_r;
  logic [21:0] qh_r;
  logic [9:0]  rh_r;
  logic [63:0] sum_r;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_r;
  out_rsp_t    out_data_r;
  logic        out_valid_r;
  logic        div_start, div_busy, div_done;
  logic [DIV_NUM_W-1:0] div_num, quo;
  logic [DIV_DEN_W-1:0] div_den;

  logic        in_acc, found, is_front;
  logic [31:0] span, numt, diffa, age;
  logic [64:0] dsum;
  logic [63:0] dsat;
  logic signed [33:0] ux;
  logic [67:0] pmag;
  logic [21:0] rh_c;
  logic [48:0] qadj;
  logic signed [49:0] esum;
  logic signed [31:0] esat;
  logic signed [67:0] lsh;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign wr_en    = in_acc && (in_data.kind == KIND_STORE);
  assign found    = (req_r.sample_time >= rd_data.stamp);
  assign is_front = (cur_r == front_r);
  assign span     = ent_b_r.stamp - ent_a_r.stamp;
  assign numt     = req_r.sample_time - ent_a_r.stamp;
  assign diffa    = req_r.sample_time - ent_a_r.stamp;
  assign age      = diffa[31] ? 32'd0 : ((diffa > AGE_MAX) ? AGE_MAX : diffa);
  assign dsum     = {1'b0, sum_r} + {1'b0, prod_r[63:0]};
  assign dsat     = dsum[64] ? '1 : dsum[63:0];
  assign pmag     = prod_r[67] ? 68'(-prod_r) : 68'(prod_r);
  assign rh_c     = mag_r[41:20] - 22'(prod_r[61:40] * 22'(MS_PER_S));
  assign qadj     = 49'({qh_r, 20'd0}) + 49'(prod_r[60:40]);
  assign esum     = 50'(ent_field(ent_a_r, k_r)) + (neg_r ? -$signed({1'b0, qadj})
                                                          : $signed({1'b0, qadj}));
  assign esat     = (esum > 50'sd2147483647) ? 32'sh7fffffff :
                    (esum < -50'sd2147483648) ? 32'sh80000000 : esum[31:0];
  assign lsh      = prod_r >>> 16;

  always_comb begin
    if (req_r.want_vel) begin
      ux = (k_r == FLD_PX) ? 34'(ent_a_r.vel_x) : 34'(ent_a_r.vel_y);
    end else if (k_r == FLD_PX) begin
      ux = 34'(ent_a_r.pos_x) - 34'(ent_b_r.pos_x);
    end else begin
      ux = 34'(ent_a_r.pos_y) - 34'(ent_b_r.pos_y);
    end
  end

  sib_ring u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (head_r),
    .wr_data ({in_data.sample_time, in_data.pos_x, in_data.pos_y,
               in_data.vel_x, in_data.vel_y, in_data.rot_in}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sib_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.kind == KIND_QUERY) begin
          state_nxt = (head_r == tail_r) ? S_OUT : S_SRCH;
        end
      end
      S_SRCH:  state_nxt = (cur_r == tail_r) ? S_TAIL : S_CMP;
      S_CMP:   state_nxt = found ? S_GETB : S_SRCH;
      S_TAIL:  state_nxt = S_OUT;
      S_GETB: begin
        if (is_front) begin
          state_nxt = req_r.want_pos ? S_EMUL : S_OUT;
        end else begin
          state_nxt = (req_r.want_pos && thr_r != '1) ? S_SQX : S_FRAC;
        end
      end
      S_SQX:   state_nxt = S_SQY;
      S_SQY:   state_nxt = S_SQC;
      S_SQC:   state_nxt = (dsat >= thr_r) ? S_OUT : S_FRAC;
      S_FRAC:  state_nxt = (span == '0 || numt >= span) ? S_LMUL : S_FDIV;
      S_FDIV:  state_nxt = div_done ? S_LMUL : S_FDIV;
      S_LMUL:  state_nxt = S_LACC;
      S_LACC:  state_nxt = (k_r == FLD_ROT) ? S_OUT : S_LMUL;
      S_EMUL:  state_nxt = S_EDIVS;
      S_EDIVS: state_nxt = S_EDIV;
      S_EDIV:  state_nxt = S_EQHI;
      S_EQHI:  state_nxt = S_ELMUL;
      S_ELMUL: state_nxt = S_EACC;
      S_EACC:  state_nxt = (k_r == FLD_PY) ? S_OUT : S_EMUL;
      S_OUT:   state_nxt = (!out_valid_r || !out_stall) ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    rd_addr   = cur_r;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = {numt, 16'h0000};
    div_den   = span;
    unique case (state_r)
      S_SRCH:  rd_addr = (cur_r == tail_r) ? tail_r : cur_r;
      S_CMP:   rd_addr = is_front ? ring_prev(cur_r) : ring_next(cur_r);
      S_SQX: begin
        mul_a = 34'(ent_b_r.pos_x) - 34'(req_r.pos_x);
        mul_b = mul_a;
      end
      S_SQY: begin
        mul_a = 34'(ent_b_r.pos_y) - 34'(req_r.pos_y);
        mul_b = mul_a;
      end
      S_FRAC:  div_start = !(span == '0 || numt >= span);
      S_LMUL: begin
        mul_a = 34'(ent_field(ent_b_r, k_r)) - 34'(ent_field(ent_a_r, k_r));
        mul_b = $signed({17'd0, f_r});
      end
      S_EMUL: begin
        mul_a = ux;
        mul_b = $signed({2'b00, age});
      end
      S_EDIV: begin
        mul_a = $signed({12'd0, mag_r[41:20]});
        mul_b = $signed({3'd0, MS_RECIP});
      end
      S_ELMUL: begin
        mul_a = $signed({4'd0, rh_r, mag_r[19:0]});
        mul_b = $signed({3'd0, MS_RECIP});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      thr_r       <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      if (wr_en) begin
        head_r <= ring_next(head_r);
        if (ring_next(head_r) == tail_r) begin
          tail_r <= ring_next(tail_r);
        end
      end
      if (state_r == S_SQC && dsat >= thr_r) begin
        tail_r <= nb_r;
      end
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        req_r   <= in_data;
        cur_r   <= ring_prev(head_r);
        front_r <= ring_prev(head_r);
        ok_r    <= 1'b0;
        k_r     <= FLD_PX;
        for (int j = 0; j < 5; j++) begin
          res_r[j] <= '0;
        end
      end
      S_CMP: begin
        if (found) begin
          ent_a_r <= rd_data;
          nb_r    <= ring_next(cur_r);
        end else begin
          cur_r <= ring_prev(cur_r);
        end
      end
      S_TAIL: begin
        for (int j = 0; j < 5; j++) begin
          res_r[j] <= ent_field(rd_data, 3'(j));
        end
      end
      S_GETB: begin
        ent_b_r <= rd_data;
        if (is_front) begin
          ok_r         <= 1'b1;
          res_r[FLD_VX] <= ent_a_r.vel_x;
          res_r[FLD_VY] <= ent_a_r.vel_y;
          res_r[FLD_ROT] <= ent_a_r.rot;
        end
      end
      S_SQY:   sum_r <= prod_r[63:0];
      S_SQC: begin
        if (dsat >= thr_r) begin
          for (int j = 0; j < 5; j++) begin
            res_r[j] <= ent_field(ent_b_r, 3'(j));
          end
        end
      end
      S_FRAC:  f_r <= FRAC_ONE;
      S_FDIV: begin
        if (div_done) begin
          f_r <= quo[16:0];
        end
      end
      S_LACC: begin
        res_r[k_r] <= ent_field(ent_a_r, k_r) + lsh[31:0];
        ok_r       <= 1'b1;
        k_r        <= 3'(k_r + 1'b1);
      end
      S_EDIVS: begin
        neg_r <= prod_r[67];
        mag_r <= pmag[41:0] + (prod_r[67] ? 42'(MS_PER_S - 32'd1) : 42'd0);
      end
      S_EQHI: begin
        qh_r <= prod_r[61:40];
        rh_r <= rh_c[9:0];
      end
      S_EACC: begin
        res_r[k_r] <= esat;
        k_r        <= 3'(k_r + 1'b1);
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_data_r.ok        <= ok_r;
          out_data_r.out_pos_x <= req_r.want_pos ? res_r[FLD_PX] : '0;
          out_data_r.out_pos_y <= req_r.want_pos ? res_r[FLD_PY] : '0;
          out_data_r.out_vel_x <= req_r.want_vel ? res_r[FLD_VX] : '0;
          out_data_r.out_vel_y <= req_r.want_vel ? res_r[FLD_VY] : '0;
          out_data_r.out_rot   <= res_r[FLD_ROT];
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_store_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (head_r != tail_r))
    else $error("ring empty after store");

  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == S_FDIV))
    else $error("divider running outside a wait state");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result raised outside output state");

endmodule

>>> design/sib_ring.sv
`timescale 1ns / 1ps
// Snapshot ring storage: one write port, one registered read port.
// Depends on sib_pkg.
module sib_ring
  import sib_pkg::*;
(
  input  logic        clk,
  input  logic        wr_en,
  input  idx_t        wr_addr,
  input  snap_entry_t wr_data,
  input  idx_t        rd_addr,
  output snap_entry_t rd_data
);

  snap_entry_t mem [RING_DEPTH];
  snap_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/sib_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sib_pkg.
module sib_div
  import sib_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 busy,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  logic [DIV_NUM_W-1:0] qn_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  assign trial = {rem_r, qn_r[DIV_NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= DIV_CNT_W'(cnt_r + 1'b1);
        if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qn_r  <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      qn_r  <= {qn_r[DIV_NUM_W-2:0], fits};
      rem_r <= fits ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = qn_r;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for snapshot_interpolation_buffer: a queued request driver, a result
// monitor and a cycle-free predictor of the snapshot ring. Depends on sib_pkg.
module tb_top;
  import sib_pkg::*;

  typedef struct {
    in_req_t req;
    bit      drain;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_req_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_rsp_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_data = '0;

  stim_t       pending[$];
  out_rsp_t    transform_q[$];
  int          errors = 0;

  logic [31:0]       stamp_m[RING_DEPTH];
  longint            px_m[RING_DEPTH];
  longint            py_m[RING_DEPTH];
  longint            vx_m[RING_DEPTH];
  longint            vy_m[RING_DEPTH];
  longint            rot_m[RING_DEPTH];
  int unsigned       head_m = 0;
  int unsigned       tail_m = 0;
  logic [63:0]       snap_limit = '1;

  int          sent = 0;
  int          gap_left = 0;
  int          seen = 0;
  int          hold_left = 0;
  logic [31:0] clock_ms = 32'd1000;
  longint      last_x = 0;
  longint      last_y = 0;

  always #5 clk = ~clk;

  snapshot_interpolation_buffer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  function automatic int unsigned step_fwd(int unsigned i);
    return (i == RING_DEPTH - 1) ? 0 : i + 1;
  endfunction

  function automatic int unsigned step_back(int unsigned i);
    return (i == 0) ? RING_DEPTH - 1 : i - 1;
  endfunction

  function automatic longint div_down(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint blend(longint a, longint b, longint f);
    return a + div_down((b - a) * f, 65536);
  endfunction

  function automatic longint unsigned square_mag(longint d);
    longint unsigned m;
    m = (d < 0) ? longint'(-d) : d;
    return m * m;
  endfunction

  // Update the ring for one accepted request; queue the transform a query yields.
  function automatic void track_request(in_req_t r);
    out_rsp_t    o;
    int unsigned front, i, n, p;
    bit          found, snapped;
    logic [31:0] diff, span, num;
    longint      age, ux, uy, f, ox, oy, vx, vy, rot;
    longint unsigned a, b, d;
    ox = 0; oy = 0; vx = 0; vy = 0; rot = 0;
    o = '0;
    if (r.kind == KIND_STORE) begin
      stamp_m[head_m] = r.sample_time;
      px_m[head_m] = r.pos_x;
      py_m[head_m] = r.pos_y;
      vx_m[head_m] = r.vel_x;
      vy_m[head_m] = r.vel_y;
      rot_m[head_m] = r.rot_in;
      head_m = step_fwd(head_m);
      if (head_m == tail_m) tail_m = step_fwd(tail_m);
      return;
    end
    if (head_m != tail_m) begin
      front = step_back(head_m);
      i = front;
      found = 0;
      while (i != tail_m && !found) begin
        if (r.sample_time >= stamp_m[i]) found = 1;
        else i = step_back(i);
      end
      if (!found) begin
        if (r.want_pos) begin ox = px_m[tail_m]; oy = py_m[tail_m]; end
        if (r.want_vel) begin vx = vx_m[tail_m]; vy = vy_m[tail_m]; end
        rot = rot_m[tail_m];
      end else if (i == front) begin
        diff = r.sample_time - stamp_m[i];
        age = diff[31] ? 0 : (diff > 32'd250 ? 250 : longint'(diff));
        if (r.want_vel) begin
          ux = vx_m[i]; uy = vy_m[i]; vx = ux; vy = uy;
        end else begin
          p = step_back(i);
          ux = px_m[i] - px_m[p];
          uy = py_m[i] - py_m[p];
        end
        if (r.want_pos) begin
          ox = clip32(px_m[i] + div_down(ux * age, 1000));
          oy = clip32(py_m[i] + div_down(uy * age, 1000));
        end
        rot = rot_m[i];
        o.ok = 1'b1;
      end else begin
        n = step_fwd(i);
        snapped = 0;
        if (r.want_pos && snap_limit != '1) begin
          a = square_mag(px_m[n] - longint'(r.pos_x));
          b = square_mag(py_m[n] - longint'(r.pos_y));
          d = (a > 64'hFFFF_FFFF_FFFF_FFFF - b) ? 64'hFFFF_FFFF_FFFF_FFFF : a + b;
          if (d >= snap_limit) begin
            ox = px_m[n]; oy = py_m[n];
            if (r.want_vel) begin vx = vx_m[n]; vy = vy_m[n]; end
            rot = rot_m[n];
            tail_m = n;
            snapped = 1;
          end
        end
        if (!snapped) begin
          span = stamp_m[n] - stamp_m[i];
          num = r.sample_time - stamp_m[i];
          if (span == 0 || num >= span) f = 65536;
          else f = longint'({16'd0, num, 16'd0} / {32'd0, span});
          if (r.want_pos) begin
            ox = blend(px_m[i], px_m[n], f);
            oy = blend(py_m[i], py_m[n], f);
          end
          if (r.want_vel) begin
            vx = blend(vx_m[i], vx_m[n], f);
            vy = blend(vy_m[i], vy_m[n], f);
          end
          rot = blend(rot_m[i], rot_m[n], f);
          o.ok = 1'b1;
        end
      end
    end
    o.out_pos_x = ox[31:0];
    o.out_pos_y = oy[31:0];
    o.out_vel_x = vx[31:0];
    o.out_vel_y = vy[31:0];
    o.out_rot = rot[31:0];
    transform_q.push_back(o);
  endfunction

  function automatic int draw_gap(int count);
    return ((count / 120) % 4 == 3) ? 0 : $urandom_range(0, 3);
  endfunction

  // Driver: offer queued requests, predict each one as it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_request(in_data);
        sent++;
        gap_left = draw_gap(sent);
      end
      if (!(in_valid && !in_stall) && in_valid) begin
        // hold the stalled request
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending.size() != 0 && !(pending[0].drain && transform_q.size() != 0)) begin
        in_data <= pending[0].req;
        in_valid <= 1'b1;
        void'(pending.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: take results with random hold-offs and one long one.
  always @(posedge clk) begin
    out_rsp_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (transform_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        e = transform_q.pop_front();
        if (e.ok !== out_data.ok)
          $display("%0t: ok expected %h actual %h", $time, e.ok, out_data.ok);
        if (e.out_pos_x !== out_data.out_pos_x)
          $display("%0t: pos_x expected %h actual %h", $time, e.out_pos_x, out_data.out_pos_x);
        if (e.out_pos_y !== out_data.out_pos_y)
          $display("%0t: pos_y expected %h actual %h", $time, e.out_pos_y, out_data.out_pos_y);
        if (e.out_vel_x !== out_data.out_vel_x)
          $display("%0t: vel_x expected %h actual %h", $time, e.out_vel_x, out_data.out_vel_x);
        if (e.out_vel_y !== out_data.out_vel_y)
          $display("%0t: vel_y expected %h actual %h", $time, e.out_vel_y, out_data.out_vel_y);
        if (e.out_rot !== out_data.out_rot)
          $display("%0t: rot expected %h actual %h", $time, e.out_rot, out_data.out_rot);
        if (e !== out_data) errors++;
      end
      seen++;
      hold_left = (seen == 150) ? 400 : draw_gap(seen + 60);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(bit kind, logic [31:0] t, logic [31:0] x, logic [31:0] y,
                          logic [31:0] vx, logic [31:0] vy, logic [31:0] rot,
                          bit wp, bit wv, bit drain);
    stim_t s;
    s.req.kind = kind;
    s.req.sample_time = t;
    s.req.pos_x = x;
    s.req.pos_y = y;
    s.req.vel_x = vx;
    s.req.vel_y = vy;
    s.req.rot_in = rot;
    s.req.want_pos = wp;
    s.req.want_vel = wv;
    s.drain = drain;
    pending.push_back(s);
  endtask

  task automatic add_random(bit drain);
    logic [31:0] t, x, y;
    bit          store;
    store = ($urandom_range(0, 99) < 45);
    if (store) begin
      clock_ms += $urandom_range(0, 40);
      t = ($urandom_range(0, 29) == 0) ? $urandom : clock_ms;
      x = pick_value();
      y = pick_value();
      last_x = longint'(signed'(x));
      last_y = longint'(signed'(y));
    end else begin
      t = ($urandom_range(0, 19) == 0) ? $urandom
          : clock_ms - $urandom_range(0, 600) + $urandom_range(0, 400);
      if ($urandom_range(0, 2) == 0) begin
        x = pick_value();
        y = pick_value();
      end else begin
        x = 32'(last_x + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
        y = 32'(last_y + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
      end
    end
    add_item(store ? KIND_STORE : KIND_QUERY, t, x, y, pick_value(), pick_value(),
             $urandom, $urandom_range(0, 1), $urandom_range(0, 1), drain);
  endtask

  task automatic wait_quiet();
    while (pending.size() != 0 || in_valid || transform_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_limit(logic [63:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    snap_limit = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [63:0] limits[7];
    limits = '{64'h0000_0001_0000_0000, 64'd0, 64'h0000_0100_0000_0000,
               64'hFFFF_FFFF_FFFF_FFFE, 64'h0, 64'h0000_0000_0001_0000, '1};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_item(KIND_QUERY, 32'd10, 0, 0, 0, 0, 0, 1, 1, 0);
    add_item(KIND_STORE, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
             32'hFFFF_0000, 32'h0003_243F, 0, 0, 0);
    add_item(KIND_QUERY, 32'd50, 0, 0, 0, 0, 0, 1, 1, 0);
    add_item(KIND_STORE, 32'd200, 32'h7FFF_0000, 32'h8001_0000, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 1, 1, 0);
    add_item(KIND_QUERY, 32'd200, 0, 0, 0, 0, 0, 1, 1, 0);
    add_item(KIND_QUERY, 32'd1000, 0, 0, 0, 0, 0, 1, 1, 0);
    add_item(KIND_QUERY, 32'd1000, 0, 0, 0, 0, 0, 1, 0, 0);
    add_item(KIND_STORE, 32'd300, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
             32'h0002_0000, 32'h7FFF_FFFF, 0, 0, 0);
    add_item(KIND_QUERY, 32'd250, 32'h0000_1000, 0, 0, 0, 0, 1, 1, 0);
    add_item(KIND_QUERY, 32'd250, 0, 0, 0, 0, 0, 0, 0, 0);
    add_item(KIND_QUERY, 32'd0, 0, 0, 0, 0, 0, 1, 0, 0);
    add_item(KIND_QUERY, 32'd300 + 32'h8000_0000, 0, 0, 0, 0, 0, 1, 0, 0);
    add_item(KIND_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 1, 1, 0);
    add_item(KIND_STORE, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h0, 0, 0, 0);
    add_item(KIND_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 1, 0, 0);
    add_item(KIND_QUERY, 32'd301, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 1, 1, 0);
    wait_quiet();

    foreach (limits[k]) begin
      write_limit((k == 4) ? {$urandom, $urandom} : limits[k]);
      for (int n = 0; n < 230; n++) add_random(n == 100);
      wait_quiet();
    end

    if (errors == 0 && transform_q.size() == 0) begin
      $display("PASS snapshot_interpolation_buffer");
    end else begin
      $display("FAIL snapshot_interpolation_buffer");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL snapshot_interpolation_buffer");
    $finish;
  end

endmodule

>>> snapshot_interpolation_buffer.f
design/sib_pkg.sv
design/sib_ring.sv
design/sib_div.sv
design/snapshot_interpolation_buffer.sv
tb/sv/tb_top.sv
